// File: hdl/alist_pkg.sv
// alist_pkg: shared types and constants for the array list engine.
// Holds operation codes, field widths and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package alist_pkg;

    // Default list capacity
    localparam int DEPTH_DEF = 128;

    // Request and result field widths
    localparam int KIND_W  = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 7;
    localparam int IDX_W   = 7;
    localparam int CNT_W   = 8;

    // Packed stream widths, rounded up to whole bytes
    localparam int S_DATA_W = ((VALUE_W + POS_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((1 + IDX_W + CNT_W + 7) / 8) * 8;

    // Operation codes
    localparam logic [KIND_W-1:0] OP_SEARCH   = 3'd0;
    localparam logic [KIND_W-1:0] OP_APPEND   = 3'd1;
    localparam logic [KIND_W-1:0] OP_DEL_LAST = 3'd2;
    localparam logic [KIND_W-1:0] OP_DEL_AT   = 3'd3;
    localparam logic [KIND_W-1:0] OP_SRCH_DEL = 3'd4;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT
    } state_t;

endpackage

// File: hdl/array_list_engine.sv
// array_list_engine: packed list of signed 32-bit values with search, append and deletes.
// Depends on alist_pkg; list storage is a single-port-write, registered-read memory.
// Shares one read port, one write port and one compare under a small sequencer.
`timescale 1ns / 1ps

// Each request transfer is one operation; each produces exactly one result transfer.
// Append, delete-last, the unused kind codes, a search or search-and-delete on an empty
// list, a delete-at with a position not below the count and a delete-at of the last
// entry complete in the accept cycle. A search walks the list one entry per cycle
// through the memory read port and the single comparator until a hit or the last
// entry. Removing an entry at index p shifts later entries down one per cycle,
// writing entry j+1 into slot j while fetching entry j+2. A search-and-delete scans
// up to the hit and shifts from there, so the list is covered once. The input is not
// ready while an operation is in progress or while a finished result waits and the
// result side is stalled.
module array_list_engine #(
    parameter int DEPTH = alist_pkg::DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Request channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [alist_pkg::S_DATA_W-1:0] s_tdata,  // value[31:0], position[38:32], zero pad
    input  logic [alist_pkg::KIND_W-1:0]   s_tuser,  // kind[2:0]
    // Result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [alist_pkg::M_DATA_W-1:0] m_tdata   // ok[0], found_index[7:1], entry_count[15:8]
);
    import alist_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Field unpacking
    logic [VALUE_W-1:0] s_value;
    logic [POS_W-1:0]   s_position;
    logic [KIND_W-1:0]  s_kind;

    assign s_value    = s_tdata[VALUE_W-1:0];
    assign s_position = s_tdata[VALUE_W+POS_W-1:VALUE_W];
    assign s_kind     = s_tuser;

    // Registers
    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [IW-1:0]      cmp_idx_reg, cmp_idx_next;
    logic [IW-1:0]      wr_idx_reg, wr_idx_next;
    logic [VALUE_W-1:0] rd_data_reg;
    logic               out_valid_reg, out_valid_next;
    logic               out_ok_reg, out_ok_next;
    logic [IDX_W-1:0]   out_idx_reg, out_idx_next;
    logic [CW-1:0]      out_cnt_reg, out_cnt_next;

    // List storage
    logic [VALUE_W-1:0] list_mem [DEPTH];
    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic [IW-1:0]      rd_addr;

    // Result load strobe
    logic               res_load;
    logic               res_ok;
    logic [IDX_W-1:0]   res_idx;
    logic [CW-1:0]      res_cnt;

    // Conditions
    logic in_xfer;
    logic cnt_zero;
    logic cnt_full;
    logic pos_ok;
    logic pos_last;
    logic scan_hit;
    logic scan_last;
    logic shift_last;

    assign s_tready   = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign in_xfer    = s_tvalid && s_tready;
    assign cnt_zero   = (count_reg == '0);
    assign cnt_full   = (count_reg == CW'(DEPTH));
    assign pos_ok     = (32'(s_position) < 32'(count_reg));
    assign pos_last   = ((32'(s_position) + 32'd1) == 32'(count_reg));
    assign scan_hit   = (rd_data_reg == value_reg);
    assign scan_last  = ((CW'(cmp_idx_reg) + CW'(1)) == count_reg);
    assign shift_last = ((CW'(wr_idx_reg) + CW'(2)) == count_reg);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if ((s_kind == OP_SEARCH || s_kind == OP_SRCH_DEL) && !cnt_zero) begin
                        state_next = ST_SCAN;
                    end else if (s_kind == OP_DEL_AT && pos_ok && !pos_last) begin
                        state_next = ST_SHIFT;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_hit) begin
                    if (kind_reg == OP_SRCH_DEL && !scan_last) begin
                        state_next = ST_SHIFT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else if (scan_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SHIFT: begin
                if (shift_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        count_next   = count_reg;
        kind_next    = kind_reg;
        value_next   = value_reg;
        cmp_idx_next = cmp_idx_reg;
        wr_idx_next  = wr_idx_reg;
        mem_we       = 1'b0;
        mem_waddr    = wr_idx_reg;
        mem_wdata    = rd_data_reg;
        rd_addr      = '0;
        res_load     = 1'b0;
        res_ok       = 1'b0;
        res_idx      = '0;
        res_cnt      = count_reg;

        case (state_reg)
            ST_IDLE: begin
                // Delete-at prefetches the entry after the gap
                if (s_kind == OP_DEL_AT) begin
                    rd_addr = IW'(s_position) + IW'(1);
                end
                if (in_xfer) begin
                    kind_next    = s_kind;
                    value_next   = s_value;
                    cmp_idx_next = '0;
                    case (s_kind)
                        OP_SEARCH, OP_SRCH_DEL: begin
                            if (cnt_zero) begin
                                res_load = 1'b1;
                            end
                        end
                        OP_APPEND: begin
                            res_load = 1'b1;
                            if (!cnt_full) begin
                                mem_we     = 1'b1;
                                mem_waddr  = IW'(count_reg);
                                mem_wdata  = s_value;
                                count_next = count_reg + CW'(1);
                                res_ok     = 1'b1;
                                res_cnt    = count_reg + CW'(1);
                            end
                        end
                        OP_DEL_LAST: begin
                            res_load = 1'b1;
                            if (!cnt_zero) begin
                                count_next = count_reg - CW'(1);
                                res_ok     = 1'b1;
                                res_cnt    = count_reg - CW'(1);
                            end
                        end
                        OP_DEL_AT: begin
                            wr_idx_next = IW'(s_position);
                            if (!pos_ok) begin
                                res_load = 1'b1;
                            end else if (pos_last) begin
                                count_next = count_reg - CW'(1);
                                res_load   = 1'b1;
                                res_ok     = 1'b1;
                                res_cnt    = count_reg - CW'(1);
                            end
                        end
                        default: begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Compare one entry a cycle; the next read is already in flight
                rd_addr = cmp_idx_reg + IW'(1);
                if (scan_hit) begin
                    if (kind_reg == OP_SEARCH) begin
                        res_load = 1'b1;
                        res_ok   = 1'b1;
                        res_idx  = IDX_W'(cmp_idx_reg);
                    end else if (scan_last) begin
                        count_next = count_reg - CW'(1);
                        res_load   = 1'b1;
                        res_ok     = 1'b1;
                        res_cnt    = count_reg - CW'(1);
                    end else begin
                        wr_idx_next = cmp_idx_reg;
                    end
                end else if (scan_last) begin
                    res_load = 1'b1;
                end else begin
                    cmp_idx_next = cmp_idx_reg + IW'(1);
                end
            end
            ST_SHIFT: begin
                // Move entry j+1 down to j, fetch j+2
                mem_we      = 1'b1;
                mem_waddr   = wr_idx_reg;
                mem_wdata   = rd_data_reg;
                rd_addr     = wr_idx_reg + IW'(2);
                wr_idx_next = wr_idx_reg + IW'(1);
                if (shift_last) begin
                    count_next = count_reg - CW'(1);
                    res_load   = 1'b1;
                    res_ok     = 1'b1;
                    res_cnt    = count_reg - CW'(1);
                end
            end
            default: ;
        endcase
    end

    // Result register
    always_comb begin
        out_valid_next = out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_idx_next   = out_idx_reg;
        out_cnt_next   = out_cnt_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (res_load) begin
            out_valid_next = 1'b1;
            out_ok_next    = res_ok;
            out_idx_next   = res_idx;
            out_cnt_next   = res_cnt;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        value_reg   <= value_next;
        cmp_idx_reg <= cmp_idx_next;
        wr_idx_reg  <= wr_idx_next;
        out_ok_reg  <= out_ok_next;
        out_idx_reg <= out_idx_next;
        out_cnt_reg <= out_cnt_next;
    end

    // Memory write port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            list_mem[mem_waddr] <= mem_wdata;
        end
    end

    // Memory read port, registered
    always_ff @(posedge aclk) begin
        rd_data_reg <= list_mem[rd_addr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'({CNT_W'(out_cnt_reg), out_idx_reg, out_ok_reg});

endmodule

// File: hdl/alist_checker.sv
// alist_checker: port-level checks for array_list_engine, attached by bind.
// Depends on alist_pkg for field widths.
`timescale 1ns / 1ps

module alist_checker #(
    parameter int DEPTH = alist_pkg::DEPTH_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [alist_pkg::S_DATA_W-1:0] s_tdata,
    input logic [alist_pkg::KIND_W-1:0]   s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [alist_pkg::M_DATA_W-1:0] m_tdata
);
    import alist_pkg::*;

    // Waiting request stays put until taken
    a_req_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("request changed while waiting");

    // Held result stays put while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // No new request while a result is stuck
    a_no_take_when_stuck: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken with result stalled");

    // Index is only reported on success
    a_idx_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[IDX_W:1] == '0)
        else $error("index reported on failure");

    // Count never exceeds capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (DEPTH > 255) || (32'(m_tdata[IDX_W+CNT_W:IDX_W+1]) <= DEPTH))
        else $error("entry count above capacity");

endmodule

bind array_list_engine alist_checker #(.DEPTH(DEPTH)) u_alist_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
